### sv/assert_macros.svh
// Assertion helpers for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a boolean expression at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: expression does not hold");

// Checks a temporal property at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: property does not hold");

`endif

### sv/wpt_pkg.sv
`timescale 1ns / 1ps

package wpt_pkg;

  localparam int unsigned DelayW = 7;
  localparam int unsigned TicksW = 14;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [DelayW-1:0] MaxDelay = 7'd99;
  localparam logic [DelayW-1:0] MinDelay = 7'd1;
  localparam logic [DelayW-1:0] ResetDelay = 7'd50;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgPulseUnit = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgInitDelay = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgFirstRep = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgFastRep = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSlowSteps = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgHoldTicks = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgSettleTicks = 3'd6;

  typedef enum logic [2:0] {
    PhIdle   = 3'd0,
    PhZc     = 3'd1,
    PhPulse  = 3'd2,
    PhManual = 3'd3,
    PhRel    = 3'd4,
    PhHold   = 3'd5,
    PhRel2   = 3'd6,
    PhSettle = 3'd7
  } phase_e;

  typedef struct packed {
    logic       zero_cross_high;
    logic       action_pressed;
    logic       mode_pressed;
    logic       minus_pressed;
    logic       plus_pressed;
  } in_item_t;

  typedef struct packed {
    logic [6:0] pulse_unit_ms;
    logic [7:0] first_repeat_ticks;
    logic [7:0] fast_repeat_ticks;
    logic [7:0] slow_step_count;
    logic [7:0] release_hold_ticks;
    logic [7:0] release_settle_ticks;
  } cfg_t;

  // Button sampling request from the phase control to the repeat logic.
  typedef struct packed {
    logic step;
    logic plus;
    logic minus;
    logic mode;
  } rep_ctrl_t;

  typedef struct packed {
    logic              load;
    logic [DelayW-1:0] value;
  } delay_load_t;

  // Segment patterns, bit 0 is segment a.
  function automatic logic [6:0] seg_of(input logic [3:0] digit);
    logic [6:0] seg;
    unique case (digit)
      4'd0:    seg = 7'b0111111;
      4'd1:    seg = 7'b0000110;
      4'd2:    seg = 7'b1011011;
      4'd3:    seg = 7'b1001111;
      4'd4:    seg = 7'b1100110;
      4'd5:    seg = 7'b1101101;
      4'd6:    seg = 7'b1111101;
      4'd7:    seg = 7'b0000111;
      4'd8:    seg = 7'b1111111;
      4'd9:    seg = 7'b1101111;
      default: seg = 7'b0000000;
    endcase
    return seg;
  endfunction

  function automatic logic [DelayW-1:0] clamp_delay(input logic [DelayW-1:0] v);
    logic [DelayW-1:0] r;
    if (v < MinDelay) begin
      r = MinDelay;
    end else if (v > MaxDelay) begin
      r = MaxDelay;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### sv/wpt_seg.sv
`timescale 1ns / 1ps

// Splits the delay into decimal digits and maps them to segment patterns.
module wpt_seg (
  input  logic [6:0] delay_i,
  output logic [6:0] ones_seg_o,
  output logic [6:0] tens_seg_o
);

  logic [14:0] prod;
  logic [3:0]  tens;
  logic [7:0]  tens_x10;
  logic [3:0]  ones;

  // Multiply by 205/2048, exact for values below 128.
  assign prod     = {8'd0, delay_i} * 15'd205;
  assign tens     = prod[14:11];
  assign tens_x10 = {4'd0, tens} * 8'd10;
  assign ones     = 4'({1'b0, delay_i} - tens_x10);

  assign ones_seg_o = wpt_pkg::seg_of(ones);
  assign tens_seg_o = wpt_pkg::seg_of(tens);

endmodule

### sv/wpt_repeat.sv
`timescale 1ns / 1ps

// Delay setting, mode toggle and accelerating auto-repeat of plus and minus.
module wpt_repeat (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wpt_pkg::cfg_t        cfg_i,
  input  wpt_pkg::delay_load_t load_i,
  input  wpt_pkg::rep_ctrl_t   rep_i,
  output logic                 timed_q_o,
  output logic [6:0]           delay_q_o,
  output logic                 timed_d_o,
  output logic [6:0]           delay_d_o
);

  logic       timed_q, timed_d;
  logic [6:0] delay_q, delay_d;
  logic [7:0] slow_wait_q, slow_wait_d;
  logic [7:0] fast_wait_q, fast_wait_d;
  logic [7:0] step_cnt_q, step_cnt_d;
  logic       fast_ph_q, fast_ph_d;
  logic       due;

  assign due = (slow_wait_q == cfg_i.first_repeat_ticks) ||
               (fast_ph_q && (fast_wait_q == cfg_i.fast_repeat_ticks));

  always_comb begin
    timed_d     = timed_q;
    delay_d     = delay_q;
    slow_wait_d = slow_wait_q;
    fast_wait_d = fast_wait_q;
    step_cnt_d  = step_cnt_q;
    fast_ph_d   = fast_ph_q;
    if (rep_i.step) begin
      if (!due) begin
        if (!fast_ph_q) begin
          slow_wait_d = slow_wait_q + 8'd1;
        end else begin
          fast_wait_d = fast_wait_q + 8'd1;
        end
      end else begin
        slow_wait_d = '0;
        fast_wait_d = '0;
        if (rep_i.mode) begin
          timed_d = ~timed_q;
        end
        // Plus and minus each count a step; both may act in one sample.
        if (rep_i.plus && timed_d) begin
          if (step_cnt_d == cfg_i.slow_step_count) begin
            fast_ph_d = 1'b1;
          end else begin
            step_cnt_d = step_cnt_d + 8'd1;
          end
          if (delay_d < wpt_pkg::MaxDelay) begin
            delay_d = delay_d + 7'd1;
          end
        end
        if (rep_i.minus && timed_d) begin
          if (step_cnt_d == cfg_i.slow_step_count) begin
            fast_ph_d = 1'b1;
          end else begin
            step_cnt_d = step_cnt_d + 8'd1;
          end
          if (delay_d > wpt_pkg::MinDelay) begin
            delay_d = delay_d - 7'd1;
          end
        end
        if (!rep_i.plus && !rep_i.minus) begin
          step_cnt_d  = '0;
          fast_ph_d   = 1'b0;
          fast_wait_d = '0;
        end
      end
    end
    if (load_i.load) begin
      delay_d = load_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timed_q     <= 1'b1;
      delay_q     <= wpt_pkg::ResetDelay;
      slow_wait_q <= '0;
      fast_wait_q <= '0;
      step_cnt_q  <= '0;
      fast_ph_q   <= 1'b0;
    end else begin
      timed_q     <= timed_d;
      delay_q     <= delay_d;
      slow_wait_q <= slow_wait_d;
      fast_wait_q <= fast_wait_d;
      step_cnt_q  <= step_cnt_d;
      fast_ph_q   <= fast_ph_d;
    end
  end

  assign timed_q_o = timed_q;
  assign delay_q_o = delay_q;
  assign timed_d_o = timed_d;
  assign delay_d_o = delay_d;

endmodule

### sv/wpt_fsm.sv
`timescale 1ns / 1ps

// Firing sequence: zero-cross wait, timed or manual pulse, release and debounce waits.
module wpt_fsm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  wpt_pkg::in_item_t  item_i,
  input  wpt_pkg::cfg_t      cfg_i,
  input  logic               timed_i,
  input  logic [6:0]         delay_i,
  output logic               weld_on_o,
  output wpt_pkg::rep_ctrl_t rep_o
);

  wpt_pkg::phase_e phase_q, phase_d;
  logic [13:0]     ticks_q, ticks_d;
  logic [13:0]     pulse_len;
  logic [13:0]     ticks_inc;
  wpt_pkg::phase_e fire_phase;

  assign pulse_len  = {7'd0, delay_i} * {7'd0, cfg_i.pulse_unit_ms};
  assign ticks_inc  = ticks_q + 14'd1;
  assign fire_phase = timed_i ? wpt_pkg::PhPulse : wpt_pkg::PhManual;

  // Next state.
  always_comb begin
    phase_d = phase_q;
    ticks_d = ticks_q;
    unique case (phase_q)
      wpt_pkg::PhIdle: begin
        if (item_i.action_pressed) begin
          if (item_i.zero_cross_high) begin
            phase_d = fire_phase;
            ticks_d = 14'd1;
          end else begin
            phase_d = wpt_pkg::PhZc;
          end
        end
      end
      wpt_pkg::PhZc: begin
        if (item_i.zero_cross_high) begin
          phase_d = fire_phase;
          ticks_d = 14'd1;
        end
      end
      wpt_pkg::PhPulse: begin
        if (ticks_q >= pulse_len) begin
          phase_d = wpt_pkg::PhRel;
          ticks_d = '0;
        end else begin
          ticks_d = ticks_inc;
        end
      end
      wpt_pkg::PhManual, wpt_pkg::PhRel: begin
        if (!item_i.action_pressed) begin
          phase_d = wpt_pkg::PhHold;
          ticks_d = '0;
        end
      end
      wpt_pkg::PhHold: begin
        ticks_d = ticks_inc;
        if (ticks_inc >= {6'd0, cfg_i.release_hold_ticks}) begin
          phase_d = wpt_pkg::PhRel2;
        end
      end
      wpt_pkg::PhRel2: begin
        if (!item_i.action_pressed) begin
          phase_d = wpt_pkg::PhSettle;
          ticks_d = '0;
        end
      end
      wpt_pkg::PhSettle: begin
        ticks_d = ticks_inc;
        if (ticks_inc >= {6'd0, cfg_i.release_settle_ticks}) begin
          phase_d = wpt_pkg::PhIdle;
          ticks_d = '0;
        end
      end
    endcase
  end

  // Outputs.
  always_comb begin
    weld_on_o   = 1'b0;
    rep_o.step  = 1'b0;
    rep_o.plus  = item_i.plus_pressed;
    rep_o.minus = item_i.minus_pressed;
    rep_o.mode  = item_i.mode_pressed;
    unique case (phase_q)
      wpt_pkg::PhIdle: begin
        if (item_i.action_pressed) begin
          weld_on_o = item_i.zero_cross_high;
        end else begin
          rep_o.step = step_i;
        end
      end
      wpt_pkg::PhZc:     weld_on_o = item_i.zero_cross_high;
      wpt_pkg::PhPulse:  weld_on_o = (ticks_q < pulse_len);
      wpt_pkg::PhManual: weld_on_o = item_i.action_pressed;
      wpt_pkg::PhRel, wpt_pkg::PhHold, wpt_pkg::PhRel2, wpt_pkg::PhSettle: begin
        weld_on_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wpt_pkg::PhIdle;
      ticks_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      ticks_q <= ticks_d;
    end
  end

endmodule

### sv/weld_pulse_timer_with_autorepeat.sv
`timescale 1ns / 1ps

// Weld pulse timer with auto-repeat delay adjustment.
// Each request on the slave stream is one 1 ms tick carrying the plus, minus,
// mode and action button levels and the zero-cross level. For every request
// the master stream delivers exactly one result: the weld drive level, the
// mode, the current delay and the two seven-segment digit patterns.
// A request is registered at the input, processed by short logic (phase
// control, repeat logic and one 7x7 multiply for the pulse length) and the
// result is registered at the output. One request is taken every cycle
// while the receiver does not stall the result stage.
// Configuration registers are to be written through cfg_we_i, cfg_idx_i and
// cfg_data_i by the user only while the block is idle; it is not enforced.
// Writing initial_delay also loads the delay, clamped to 1..99.
// Unknown indexes are ignored. Reset puts the block in idle with timed mode,
// delay 50 and the default register values; both stream stages come up empty.
// When the receiver stalls, the result holds and an empty input stage takes
// one more request before s_axis_tready drops.
module weld_pulse_timer_with_autorepeat (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  // Tick requests.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] plus_pressed, [1] minus_pressed, [2] mode_pressed,
  // [3] action_pressed, [4] zero_cross_high, [7:5] zero
  input  logic [7:0]  s_axis_tdata,
  // Results.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] weld_on, [1] auto_timed, [8:2] delay_units, [15:9] ones_segments,
  // [22:16] tens_segments, [23] zero
  output logic [23:0] m_axis_tdata
);

  wpt_pkg::cfg_t        cfg_q;
  wpt_pkg::delay_load_t delay_load;
  wpt_pkg::rep_ctrl_t   rep;
  wpt_pkg::in_item_t    in_item_q;
  logic                 in_valid_q;
  logic                 out_valid_q;
  logic [23:0]          out_data_q;
  logic                 advance;
  logic                 step;
  logic                 weld_on;
  logic                 timed_q, timed_d;
  logic [6:0]           delay_q, delay_d;
  logic [6:0]           ones_seg, tens_seg;

  // The result stage moves when empty or taken; the input stage behind it.
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign step          = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_unit_ms        <= 7'd10;
      cfg_q.first_repeat_ticks   <= 8'd250;
      cfg_q.fast_repeat_ticks    <= 8'd50;
      cfg_q.slow_step_count      <= 8'd10;
      cfg_q.release_hold_ticks   <= 8'd250;
      cfg_q.release_settle_ticks <= 8'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wpt_pkg::CfgPulseUnit:   cfg_q.pulse_unit_ms        <= cfg_data_i[6:0];
        wpt_pkg::CfgFirstRep:    cfg_q.first_repeat_ticks   <= cfg_data_i;
        wpt_pkg::CfgFastRep:     cfg_q.fast_repeat_ticks    <= cfg_data_i;
        wpt_pkg::CfgSlowSteps:   cfg_q.slow_step_count      <= cfg_data_i;
        wpt_pkg::CfgHoldTicks:   cfg_q.release_hold_ticks   <= cfg_data_i;
        wpt_pkg::CfgSettleTicks: cfg_q.release_settle_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Writing initial_delay loads the live delay as well.
  assign delay_load.load  = cfg_we_i && (cfg_idx_i == wpt_pkg::CfgInitDelay);
  assign delay_load.value = wpt_pkg::clamp_delay(cfg_data_i[6:0]);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q <= wpt_pkg::in_item_t'(s_axis_tdata[4:0]);
    end
  end

  wpt_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (in_item_q),
    .cfg_i     (cfg_q),
    .timed_i   (timed_q),
    .delay_i   (delay_q),
    .weld_on_o (weld_on),
    .rep_o     (rep)
  );

  wpt_repeat u_repeat (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .load_i    (delay_load),
    .rep_i     (rep),
    .timed_q_o (timed_q),
    .delay_q_o (delay_q),
    .timed_d_o (timed_d),
    .delay_d_o (delay_d)
  );

  wpt_seg u_seg (
    .delay_i    (delay_d),
    .ones_seg_o (ones_seg),
    .tens_seg_o (tens_seg)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= {1'b0, tens_seg, ones_seg, delay_d, timed_d, weld_on};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### sv/wpt_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wpt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  logic       out_stall;
  logic       in_accept;
  logic [6:0] out_delay;
  logic       delay_ok;
  logic       tens_ok;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_delay = m_axis_tdata[8:2];
  assign delay_ok  = (out_delay >= wpt_pkg::MinDelay) && (out_delay <= wpt_pkg::MaxDelay);
  assign tens_ok   = (out_delay >= 7'd10) || (m_axis_tdata[22:16] == 7'b0111111);

  // A stalled result keeps its contents.
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, (out_stall |=> m_axis_tvalid && $stable(m_axis_tdata)))

  // The delay shown always stays within 1..99.
  `ASSERT_ALWAYS(a_delay_range, clk_i, rst_ni, (!m_axis_tvalid || delay_ok))

  // A single-digit delay shows a zero in the tens place.
  `ASSERT_ALWAYS(a_tens_zero, clk_i, rst_ni, (!m_axis_tvalid || tens_ok))

  // A result appearing on an empty output came from a request that passed through the input and result registers.
  `ASSERT_PROP(a_latency, clk_i, rst_ni, ($rose(m_axis_tvalid) |-> $past(in_accept, 2)))

endmodule

bind weld_pulse_timer_with_autorepeat wpt_checker u_wpt_checker (.*);
